// ===== sv/conv3x3_multi_filter_macros.svh =====
// Assertion macros shared by the convolution block.
`ifndef CONV3X3_MULTI_FILTER_MACROS_SVH
`define CONV3X3_MULTI_FILTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define C3MF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define C3MF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/c3mf_pkg.sv =====
// Types and constants of the 3x3 multi-filter convolution block.
package c3mf_pkg;

    localparam int TAPS        = 9;
    localparam int PIX_W       = 16;
    localparam int COEF_W      = 16;
    localparam int PROD_W      = PIX_W + COEF_W;
    localparam int PART_W      = PROD_W + 2;
    localparam int RESP_W      = 36;
    localparam int FILT_W      = 3;
    localparam int TAP_W       = 4;
    localparam int POS_W       = 5;

    typedef enum logic {
        OP_COEF  = 1'b0,
        OP_PIXEL = 1'b1
    } t_op;

    typedef struct packed {
        t_op                       op;
        logic signed [PIX_W-1:0]   pixel;
        logic [FILT_W-1:0]         coef_filter;
        logic [TAP_W-1:0]          coef_tap;
        logic signed [COEF_W-1:0]  coef_value;
    } t_in_item;

    typedef struct packed {
        logic [FILT_W-1:0]         filter_index;
        logic [POS_W-1:0]          out_row;
        logic [POS_W-1:0]          out_col;
        logic signed [RESP_W-1:0]  response;
        logic                      last_of_pixel;
    } t_out_item;

    typedef logic [TAPS-1:0][PIX_W-1:0]  t_win;
    typedef logic [TAPS-1:0][COEF_W-1:0] t_taps;

    // Window completion report from the line buffer.
    typedef struct packed {
        logic              start;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
    } t_job;

    // Sideband carried along the multiply-add pipeline.
    typedef struct packed {
        logic [FILT_W-1:0] filter;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic              last;
    } t_tag;

endpackage

// ===== sv/c3mf_front.sv =====
// Line buffers, 3x3 window and raster counters.
module c3mf_front #(
    parameter int IMAGE_WIDTH = 28
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_pix_en,
    input  logic [c3mf_pkg::PIX_W-1:0]    i_pixel,
    output c3mf_pkg::t_win                o_win,
    output c3mf_pkg::t_job                o_job
);

    localparam int CW = $clog2(IMAGE_WIDTH);

    logic [c3mf_pkg::PIX_W-1:0] r_line0 [IMAGE_WIDTH];
    logic [c3mf_pkg::PIX_W-1:0] r_line1 [IMAGE_WIDTH];
    logic [c3mf_pkg::PIX_W-1:0] r_rd0;
    logic [c3mf_pkg::PIX_W-1:0] r_rd1;
    logic [CW-1:0]              r_col;
    logic [CW-1:0]              n_col;
    logic [CW-1:0]              r_row;
    logic [CW-1:0]              n_row;
    c3mf_pkg::t_win             r_win;
    c3mf_pkg::t_win             n_win;
    logic                       col_end;
    logic                       row_end;

    assign col_end = (r_col == CW'(IMAGE_WIDTH - 1));
    assign row_end = (r_row == CW'(IMAGE_WIDTH - 1));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_win = r_win;
        if (i_pix_en) begin
            n_col = col_end ? '0 : r_col + CW'(1);
            if (col_end) begin
                n_row = row_end ? '0 : r_row + CW'(1);
            end
            for (int a = 0; a < 3; a++) begin
                n_win[a*3]     = r_win[a*3 + 1];
                n_win[a*3 + 1] = r_win[a*3 + 2];
            end
            n_win[2] = r_rd0;
            n_win[5] = r_rd1;
            n_win[8] = i_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_win <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_win <= n_win;
        end
    end

    // Prefetch the column that the next pixel will read.
    always_ff @(posedge i_clk) begin
        if (i_pix_en) begin
            r_line0[r_col] <= r_rd1;
            r_line1[r_col] <= i_pixel;
        end
        r_rd0 <= r_line0[n_col];
        r_rd1 <= r_line1[n_col];
    end

    assign o_win     = n_win;
    assign o_job.start = i_pix_en && (r_row >= CW'(2)) && (r_col >= CW'(2));
    assign o_job.row = c3mf_pkg::POS_W'(32'(r_row) - 32'd2);
    assign o_job.col = c3mf_pkg::POS_W'(32'(r_col) - 32'd2);

endmodule

// ===== sv/c3mf_coef.sv =====
// Filter coefficient store, one row of nine taps per filter.
module c3mf_coef #(
    parameter int NUM_FILTERS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [c3mf_pkg::FILT_W-1:0]    i_wr_filter,
    input  logic [c3mf_pkg::TAP_W-1:0]     i_wr_tap,
    input  logic [c3mf_pkg::COEF_W-1:0]    i_wr_value,
    input  logic [c3mf_pkg::FILT_W-1:0]    i_rd_filter,
    output c3mf_pkg::t_taps                o_rd_taps
);

    localparam int FIDX_W = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;

    c3mf_pkg::t_taps r_rows [NUM_FILTERS];
    logic            wr_ok;

    assign wr_ok = i_wr_en && (32'(i_wr_filter) < NUM_FILTERS)
                   && (32'(i_wr_tap) < c3mf_pkg::TAPS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int f = 0; f < NUM_FILTERS; f++) begin
                r_rows[f] <= '0;
            end
        end else if (wr_ok) begin
            r_rows[i_wr_filter[FIDX_W-1:0]][i_wr_tap] <= i_wr_value;
        end
    end

    assign o_rd_taps = r_rows[i_rd_filter[FIDX_W-1:0]];

endmodule

// ===== sv/c3mf_mac.sv =====
// Multiply-add pipeline: products, partial sums, result register.
module c3mf_mac (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_issue,
    input  c3mf_pkg::t_tag       i_tag,
    input  c3mf_pkg::t_win       i_win,
    input  c3mf_pkg::t_taps      i_taps,
    input  logic                 i_stall,
    output logic                 o_adv,
    output logic                 o_valid,
    output c3mf_pkg::t_out_item  o_data
);

    logic                                 r_p_valid;
    c3mf_pkg::t_tag                       r_p_tag;
    logic signed [c3mf_pkg::PROD_W-1:0]   r_prod [c3mf_pkg::TAPS];
    logic                                 r_s_valid;
    c3mf_pkg::t_tag                       r_s_tag;
    logic signed [c3mf_pkg::PART_W-1:0]   r_part [3];
    logic                                 r_o_valid;
    c3mf_pkg::t_out_item                  r_o_data;

    assign o_adv = !r_o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_s_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (o_adv) begin
            r_p_valid <= i_issue;
            r_s_valid <= r_p_valid;
            r_o_valid <= r_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_p_tag <= i_tag;
            for (int k = 0; k < c3mf_pkg::TAPS; k++) begin
                r_prod[k] <= $signed(i_win[k]) * $signed(i_taps[k]);
            end
            r_s_tag <= r_p_tag;
            for (int j = 0; j < 3; j++) begin
                r_part[j] <= c3mf_pkg::PART_W'(r_prod[3*j])
                           + c3mf_pkg::PART_W'(r_prod[3*j + 1])
                           + c3mf_pkg::PART_W'(r_prod[3*j + 2]);
            end
            r_o_data.filter_index  <= r_s_tag.filter;
            r_o_data.out_row       <= r_s_tag.row;
            r_o_data.out_col       <= r_s_tag.col;
            r_o_data.last_of_pixel <= r_s_tag.last;
            r_o_data.response      <= c3mf_pkg::RESP_W'(r_part[0])
                                    + c3mf_pkg::RESP_W'(r_part[1])
                                    + c3mf_pkg::RESP_W'(r_part[2]);
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

endmodule

// ===== sv/conv3x3_multi_filter.sv =====
// Top level of the 3x3 multi-filter convolution block.
//
//   port group     dir  handshake          payload
//   item in        in   i_valid / o_stall  i_data  (t_in_item)
//   result out     out  o_valid / i_stall  o_data  (t_out_item)
//
// A coefficient write or a pixel that completes no window leaves the block
// ready. For a completed window the single multiply-add pipeline issues one
// filter per cycle unless the result side stalls, and the next beat is
// taken in the cycle of the last issue. Issues pass product, partial-sum
// and result registers. Synchronous active-low reset clears counters,
// window and coefficients. An i_stall with o_valid high holds the pipeline.
`include "conv3x3_multi_filter_macros.svh"

module conv3x3_multi_filter #(
    parameter int IMAGE_WIDTH = 28,
    parameter int NUM_FILTERS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  c3mf_pkg::t_in_item    i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output c3mf_pkg::t_out_item   o_data
);

    localparam int FIDX_W = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;

    logic                           r_busy;
    logic [FIDX_W-1:0]              r_filt;
    logic [c3mf_pkg::POS_W-1:0]     r_jrow;
    logic [c3mf_pkg::POS_W-1:0]     r_jcol;
    logic                           accept;
    logic                           pix_en;
    logic                           coef_en;
    logic                           last;
    logic                           adv;
    c3mf_pkg::t_job                 job;
    c3mf_pkg::t_win                 win;
    c3mf_pkg::t_taps                taps;
    c3mf_pkg::t_tag                 tag;

    assign last    = (r_filt == FIDX_W'(NUM_FILTERS - 1));
    assign o_stall = r_busy && !(last && adv);
    assign accept  = i_valid && !o_stall;
    assign pix_en  = accept && (i_data.op == c3mf_pkg::OP_PIXEL);
    assign coef_en = accept && (i_data.op == c3mf_pkg::OP_COEF);

    c3mf_front #(
        .IMAGE_WIDTH (IMAGE_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pix_en (pix_en),
        .i_pixel  (i_data.pixel),
        .o_win    (win),
        .o_job    (job)
    );

    c3mf_coef #(
        .NUM_FILTERS (NUM_FILTERS)
    ) u_coef (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (coef_en),
        .i_wr_filter (i_data.coef_filter),
        .i_wr_tap    (i_data.coef_tap),
        .i_wr_value  (i_data.coef_value),
        .i_rd_filter (tag.filter),
        .o_rd_taps   (taps)
    );

    assign tag.filter = c3mf_pkg::FILT_W'(r_filt);
    assign tag.row    = r_jrow;
    assign tag.col    = r_jcol;
    assign tag.last   = last;

    // The window register updates only at accept, so the pipeline reads
    // the stored window; front's win output is its next value.
    c3mf_pkg::t_win r_win_hold;

    always_ff @(posedge i_clk) begin
        r_win_hold <= win;
    end

    c3mf_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_issue (r_busy),
        .i_tag   (tag),
        .i_win   (r_win_hold),
        .i_taps  (taps),
        .i_stall (i_stall),
        .o_adv   (adv),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_filt <= '0;
        end else if (job.start) begin
            r_busy <= 1'b1;
            r_filt <= '0;
        end else if (r_busy && adv) begin
            if (last) begin
                r_busy <= 1'b0;
            end else begin
                r_filt <= r_filt + FIDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (job.start) begin
            r_jrow <= job.row;
            r_jcol <= job.col;
        end
    end

    `C3MF_ASSERT_NOW(a_start_only_at_end, i_clk, i_rst_n, job.start && r_busy, last && adv, "window started while previous job issues")
    `C3MF_ASSERT_NOW(a_filt_range, i_clk, i_rst_n, r_busy, 32'(r_filt) < NUM_FILTERS, "filter counter out of range")
    `C3MF_ASSERT_NOW(a_last_filter, i_clk, i_rst_n, o_valid && o_data.last_of_pixel, o_data.filter_index == c3mf_pkg::FILT_W'(NUM_FILTERS - 1), "last flag on wrong filter")
    `C3MF_ASSERT_NEXT(a_job_issues, i_clk, i_rst_n, job.start, r_busy && (r_filt == '0), "window completion did not start a job")

endmodule
